/* rtl/segment_box_intersect_top_macros.svh */
// assertion macros for the segment versus box test
`ifndef SEGMENT_BOX_INTERSECT_TOP_MACROS_SVH
`define SEGMENT_BOX_INTERSECT_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define SBI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SBI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sbi_pkg.sv */
// types and constants of the segment versus box test
`timescale 1ns / 1ps

package sbi_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [2:0] CFG_BOX_MIN_Y = 3'd1;
    localparam logic [2:0] CFG_BOX_MIN_Z = 3'd2;
    localparam logic [2:0] CFG_BOX_MAX_X = 3'd3;
    localparam logic [2:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [2:0] CFG_BOX_MAX_Z = 3'd5;

    // step counts of the iterative units
    localparam int T_STEPS    = 17;  // quotient bits of t
    localparam int SQRT_STEPS = 32;  // result bits of the length root
    localparam int N_STEPS    = 15;  // quotient bits of a normal component

    localparam logic signed [15:0] NORM_POS = 16'sd16384;
    localparam logic signed [15:0] NORM_NEG = -16'sd16384;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] extent_x;
        logic signed [31:0] extent_y;
        logic signed [31:0] extent_z;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic               inside_res;
        logic [16:0]        hit_param;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } out_t;

    // per-item slab decode
    typedef struct packed {
        logic [2:0] cand;      // origin outside the slab, entry candidate
        logic [2:0] face_pos;  // candidate sits on the max face
        logic       any_miss;
        logic       all_inside;
    } slab_ctl_t;

    // hit side result waiting for the normal side
    typedef struct packed {
        logic        hit;
        logic        org_in;
        logic [16:0] t;
        logic [2:0]  nwin;     // one-hot face axis of a plain hit
        logic        npos;
    } hit_rec_t;

endpackage

/* rtl/segment_box_intersect_top.sv */
// segment versus axis-aligned box test, slab method, fully pipelined
// the result at the m_ port waits on the extent squares, the 32-step length root and
//   the 15-step normal divider
// throughput: one request per cycle; every stage takes a new request each cycle and
//   the input stalls only while a result waits at the m_ port
// reset: aresetn low clears the box registers to zero and empties the pipeline
`timescale 1ns / 1ps

`include "segment_box_intersect_top_macros.svh"

module segment_box_intersect_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  sbi_pkg::in_t      s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sbi_pkg::out_t     m_data
);

    // stage map
    //   0        slab decode against the box
    //   1..17    t divider, one quotient bit per stage (three axes side by side)
    //   18       winning axis select
    //   19       hit point products extent * t
    //   20       inclusive face checks, hit record
    //   1..2     squares of the extent, their sum (in parallel with the above)
    //   3..34    integer square root, one result bit per stage
    //   35       normal numerators and denominator
    //   36..50   normal divider, one quotient bit per stage
    //   51       output register
    localparam int HIT_DONE = 20;
    localparam int SQ_DONE  = 2;
    localparam int PREP_ST  = SQ_DONE + sbi_pkg::SQRT_STEPS + 1;
    localparam int NRM_DONE = PREP_ST + sbi_pkg::N_STEPS;
    localparam int OUT_ST   = NRM_DONE + 1;
    localparam int REC_DLY  = NRM_DONE - HIT_DONE;
    localparam int TD       = sbi_pkg::T_STEPS;

    // box registers
    logic signed [31:0] box_min_reg [0:2];
    logic signed [31:0] box_max_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                box_min_reg[a] <= '0;
                box_max_reg[a] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sbi_pkg::CFG_BOX_MIN_X: box_min_reg[0] <= cfg_wdata;
                sbi_pkg::CFG_BOX_MIN_Y: box_min_reg[1] <= cfg_wdata;
                sbi_pkg::CFG_BOX_MIN_Z: box_min_reg[2] <= cfg_wdata;
                sbi_pkg::CFG_BOX_MAX_X: box_max_reg[0] <= cfg_wdata;
                sbi_pkg::CFG_BOX_MAX_Y: box_max_reg[1] <= cfg_wdata;
                sbi_pkg::CFG_BOX_MAX_Z: box_max_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output register is empty or being taken
    logic en;
    logic vld_reg [0:OUT_ST];

    assign en      = !vld_reg[OUT_ST] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[OUT_ST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= OUT_ST; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i <= OUT_ST; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // ---------------- stage 0: slab decode ----------------
    logic signed [31:0] org_c [0:2];
    logic signed [31:0] ext_c [0:2];
    logic signed [32:0] dlo_c [0:2];
    logic signed [32:0] dhi_c [0:2];
    logic [31:0]        dmag_c [0:2];
    logic [31:0]        emag_c [0:2];
    sbi_pkg::slab_ctl_t ctl_c;

    assign org_c[0] = s_data.origin_x;
    assign org_c[1] = s_data.origin_y;
    assign org_c[2] = s_data.origin_z;
    assign ext_c[0] = s_data.extent_x;
    assign ext_c[1] = s_data.extent_y;
    assign ext_c[2] = s_data.extent_z;

    always_comb begin
        logic               below;
        logic               above;
        logic               miss;
        logic signed [32:0] ext33;
        logic [32:0]        neg_dhi;
        ctl_c = '0;
        for (int a = 0; a < 3; a++) begin
            dlo_c[a] = $signed({box_min_reg[a][31], box_min_reg[a]})
                     - $signed({org_c[a][31], org_c[a]});
            dhi_c[a] = $signed({box_max_reg[a][31], box_max_reg[a]})
                     - $signed({org_c[a][31], org_c[a]});
            ext33    = $signed({ext_c[a][31], ext_c[a]});
            below    = org_c[a] < box_min_reg[a];
            above    = !below && (org_c[a] > box_max_reg[a]);
            // below the min face the extent must reach up, above the max face down
            miss     = (below && (ext33 < dlo_c[a])) || (above && (dhi_c[a] < ext33));
            neg_dhi  = -dhi_c[a];
            dmag_c[a] = below ? dlo_c[a][31:0] : neg_dhi[31:0];
            emag_c[a] = ext_c[a][31] ? (~ext_c[a] + 32'd1) : ext_c[a];
            ctl_c.cand[a]     = below || above;
            ctl_c.face_pos[a] = above;
            ctl_c.any_miss    = ctl_c.any_miss | miss;
        end
        ctl_c.all_inside = ~|ctl_c.cand;
    end

    // ---------------- hit side carry registers ----------------
    sbi_pkg::slab_ctl_t hctl_reg [0:TD];
    logic signed [31:0] hext_reg [0:TD][0:2];
    logic signed [32:0] hdlo_reg [0:TD][0:2];
    logic signed [32:0] hdhi_reg [0:TD][0:2];
    logic [31:0]        hdiv_reg [0:TD-1][0:2];
    logic [32:0]        hrem_reg [0:TD-1][0:2];
    logic [16:0]        hq_reg   [1:TD][0:2];
    logic [32:0]        hrem_next [1:TD-1][0:2];
    logic [16:0]        hq_next   [1:TD][0:2];

    always_ff @(posedge aclk) begin
        if (en) begin
            hctl_reg[0] <= ctl_c;
            for (int a = 0; a < 3; a++) begin
                hext_reg[0][a] <= ext_c[a];
                hdlo_reg[0][a] <= dlo_c[a];
                hdhi_reg[0][a] <= dhi_c[a];
                hdiv_reg[0][a] <= emag_c[a];
                hrem_reg[0][a] <= {1'b0, dmag_c[a]};
            end
            for (int k = 1; k <= TD; k++) begin
                hctl_reg[k] <= hctl_reg[k-1];
                for (int a = 0; a < 3; a++) begin
                    hext_reg[k][a] <= hext_reg[k-1][a];
                    hdlo_reg[k][a] <= hdlo_reg[k-1][a];
                    hdhi_reg[k][a] <= hdhi_reg[k-1][a];
                    hq_reg[k][a]   <= hq_next[k][a];
                end
            end
            for (int k = 1; k < TD; k++) begin
                for (int a = 0; a < 3; a++) begin
                    hdiv_reg[k][a] <= hdiv_reg[k-1][a];
                    hrem_reg[k][a] <= hrem_next[k][a];
                end
            end
        end
    end

    // t = floor(|d| * 2^16 / |e|); |d| <= |e| for a candidate so 17 bits suffice
    for (genvar k = 1; k <= TD; k++) begin : g_tdiv
        for (genvar a = 0; a < 3; a++) begin : g_ax
            logic [32:0] sh;
            logic [32:0] dv;
            logic        ge;
            assign dv = {1'b0, hdiv_reg[k-1][a]};
            if (k == 1) begin : g_first
                assign sh = hrem_reg[k-1][a];
                assign hq_next[k][a] = {16'd0, ge};
            end else begin : g_rest
                assign sh = {hrem_reg[k-1][a][31:0], 1'b0};
                assign hq_next[k][a] = {hq_reg[k-1][a][15:0], ge};
            end
            assign ge = sh >= dv;
            if (k < TD) begin : g_rem
                assign hrem_next[k][a] = ge ? (sh - dv) : sh;
            end
        end
    end

    // ---------------- stage 18: winning axis ----------------
    logic [17:0] key_c [0:2];
    logic        x_ge_c;
    logic        z_win_c;
    logic [17:0] kxy_c;
    logic [2:0]  win_c;
    logic [16:0] wt_c;
    logic        wface_c;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            // an axis inside its slab ranks below every real candidate
            key_c[a] = hctl_reg[TD].cand[a] ? {1'b1, hq_reg[TD][a]} : 18'd0;
        end
        x_ge_c  = key_c[0] >= key_c[1];
        kxy_c   = x_ge_c ? key_c[0] : key_c[1];
        z_win_c = key_c[2] > kxy_c;
        if (z_win_c) begin
            win_c   = 3'b100;
            wt_c    = hq_reg[TD][2];
            wface_c = hctl_reg[TD].face_pos[2];
        end else if (x_ge_c) begin
            win_c   = 3'b001;
            wt_c    = hq_reg[TD][0];
            wface_c = hctl_reg[TD].face_pos[0];
        end else begin
            win_c   = 3'b010;
            wt_c    = hq_reg[TD][1];
            wface_c = hctl_reg[TD].face_pos[1];
        end
    end

    logic [2:0]         s18_win_reg;
    logic [16:0]        s18_t_reg;
    logic               s18_face_reg;
    logic               s18_hc_reg;
    logic               s18_inside_reg;
    logic signed [31:0] s18_ext_reg [0:2];
    logic signed [32:0] s18_dlo_reg [0:2];
    logic signed [32:0] s18_dhi_reg [0:2];

    // ---------------- stage 19: products ----------------
    logic [2:0]         s19_win_reg;
    logic [16:0]        s19_t_reg;
    logic               s19_face_reg;
    logic               s19_hc_reg;
    logic               s19_inside_reg;
    logic signed [49:0] s19_prod_reg [0:2];
    logic signed [32:0] s19_dlo_reg [0:2];
    logic signed [32:0] s19_dhi_reg [0:2];
    logic signed [49:0] prod_next [0:2];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod_next[a] = s18_ext_reg[a] * $signed({1'b0, s18_t_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s18_win_reg    <= win_c;
            s18_t_reg      <= wt_c;
            s18_face_reg   <= wface_c;
            s18_hc_reg     <= !hctl_reg[TD].any_miss && !hctl_reg[TD].all_inside;
            s18_inside_reg <= !hctl_reg[TD].any_miss && hctl_reg[TD].all_inside;
            s19_win_reg    <= s18_win_reg;
            s19_t_reg      <= s18_t_reg;
            s19_face_reg   <= s18_face_reg;
            s19_hc_reg     <= s18_hc_reg;
            s19_inside_reg <= s18_inside_reg;
            for (int a = 0; a < 3; a++) begin
                s18_ext_reg[a]  <= hext_reg[TD][a];
                s18_dlo_reg[a]  <= hdlo_reg[TD][a];
                s18_dhi_reg[a]  <= hdhi_reg[TD][a];
                s19_prod_reg[a] <= prod_next[a];
                s19_dlo_reg[a]  <= s18_dlo_reg[a];
                s19_dhi_reg[a]  <= s18_dhi_reg[a];
            end
        end
    end

    // ---------------- stage 20: face checks ----------------
    // o*2^16 + e*t within [min*2^16, max*2^16] is e*t within [(min-o)*2^16, (max-o)*2^16]
    logic [2:0]        inb_c;
    logic              pass_c;
    logic              plain_hit_c;
    sbi_pkg::hit_rec_t rec_c;

    always_comb begin
        logic signed [48:0] lo_b;
        logic signed [48:0] hi_b;
        for (int a = 0; a < 3; a++) begin
            lo_b     = $signed({s19_dlo_reg[a], 16'd0});
            hi_b     = $signed({s19_dhi_reg[a], 16'd0});
            inb_c[a] = (s19_prod_reg[a] >= lo_b) && (s19_prod_reg[a] <= hi_b);
        end
        if (s19_win_reg[2]) begin
            pass_c = inb_c[0] && inb_c[1];
        end else if (s19_win_reg[0]) begin
            pass_c = inb_c[1] && inb_c[2];
        end else begin
            pass_c = inb_c[0] && inb_c[2];
        end
        plain_hit_c = s19_hc_reg && pass_c;
        rec_c.hit    = s19_inside_reg || plain_hit_c;
        rec_c.org_in = s19_inside_reg;
        rec_c.t      = plain_hit_c ? s19_t_reg : 17'd0;
        rec_c.nwin   = plain_hit_c ? s19_win_reg : 3'b000;
        rec_c.npos   = s19_face_reg;
    end

    // hit record waits for the normal side
    sbi_pkg::hit_rec_t rec_reg [0:REC_DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            rec_reg[0] <= rec_c;
            for (int i = 1; i <= REC_DLY; i++) rec_reg[i] <= rec_reg[i-1];
        end
    end

    // ---------------- normal side: squares, sum, root ----------------
    logic [63:0] nsq_reg  [0:2];
    logic [31:0] nmag_reg [1:PREP_ST-1][0:2];
    logic        epos_reg [1:NRM_DONE][0:2];
    logic [63:0] sn_reg   [0:sbi_pkg::SQRT_STEPS-1];
    logic [63:0] sr_reg   [1:sbi_pkg::SQRT_STEPS];
    logic [63:0] sn_next  [1:sbi_pkg::SQRT_STEPS-1];
    logic [63:0] sr_next  [1:sbi_pkg::SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                nsq_reg[a]     <= hdiv_reg[0][a] * hdiv_reg[0][a];
                nmag_reg[1][a] <= hdiv_reg[0][a];
                epos_reg[1][a] <= hext_reg[0][a] > 32'sd0;
                for (int i = 2; i < PREP_ST; i++) nmag_reg[i][a] <= nmag_reg[i-1][a];
                for (int i = 2; i <= NRM_DONE; i++) epos_reg[i][a] <= epos_reg[i-1][a];
            end
            sn_reg[0] <= nsq_reg[0] + nsq_reg[1] + nsq_reg[2];
            for (int k = 1; k < sbi_pkg::SQRT_STEPS; k++) sn_reg[k] <= sn_next[k];
            for (int k = 1; k <= sbi_pkg::SQRT_STEPS; k++) sr_reg[k] <= sr_next[k];
        end
    end

    // bit-pair restoring square root, trial bit 2^(64-2k) at step k
    for (genvar k = 1; k <= sbi_pkg::SQRT_STEPS; k++) begin : g_sqrt
        logic [63:0] rin;
        logic [63:0] trial;
        logic        ge;
        localparam logic [63:0] BITV = 64'd1 << (64 - 2 * k);
        if (k == 1) begin : g_first
            assign rin = 64'd0;
        end else begin : g_rest
            assign rin = sr_reg[k-1];
        end
        assign trial = rin + BITV;
        assign ge    = sn_reg[k-1] >= trial;
        assign sr_next[k] = ge ? ((rin >> 1) + BITV) : (rin >> 1);
        if (k < sbi_pkg::SQRT_STEPS) begin : g_n
            assign sn_next[k] = ge ? (sn_reg[k-1] - trial) : sn_reg[k-1];
        end
    end

    // ---------------- normal side: rounded |e| * 16384 / L ----------------
    localparam int NS = sbi_pkg::N_STEPS;

    logic [31:0] len_c;
    logic [47:0] nrem_reg  [0:NS-1][0:2];
    logic [14:0] nq_reg    [1:NS][0:2];
    logic [32:0] nden_reg  [0:NS-1];
    logic        nnz_reg   [0:NS];
    logic [47:0] nrem_next [1:NS-1][0:2];
    logic [14:0] nq_next   [1:NS][0:2];

    assign len_c = sr_reg[sbi_pkg::SQRT_STEPS][31:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            // numerator |e|*32768 + L over 2L gives round to nearest
            for (int a = 0; a < 3; a++) begin
                nrem_reg[0][a] <= {1'b0, nmag_reg[PREP_ST-1][a], 15'd0} + {16'd0, len_c};
            end
            nden_reg[0] <= {len_c, 1'b0};
            nnz_reg[0]  <= len_c != 32'd0;
            for (int j = 1; j <= NS; j++) begin
                nnz_reg[j] <= nnz_reg[j-1];
                for (int a = 0; a < 3; a++) nq_reg[j][a] <= nq_next[j][a];
            end
            for (int j = 1; j < NS; j++) begin
                nden_reg[j] <= nden_reg[j-1];
                for (int a = 0; a < 3; a++) nrem_reg[j][a] <= nrem_next[j][a];
            end
        end
    end

    // quotient never reaches 2^15, so only shifted divisors up to 2^14 are tried
    for (genvar j = 1; j <= NS; j++) begin : g_ndiv
        for (genvar a = 0; a < 3; a++) begin : g_ax
            logic [47:0] shd;
            logic        ge;
            assign shd = {15'd0, nden_reg[j-1]} << (NS - j);
            assign ge  = nrem_reg[j-1][a] >= shd;
            if (j == 1) begin : g_first
                assign nq_next[j][a] = {14'd0, ge};
            end else begin : g_rest
                assign nq_next[j][a] = {nq_reg[j-1][a][13:0], ge};
            end
            if (j < NS) begin : g_rem
                assign nrem_next[j][a] = ge ? (nrem_reg[j-1][a] - shd) : nrem_reg[j-1][a];
            end
        end
    end

    // ---------------- output register ----------------
    sbi_pkg::out_t     out_reg;
    sbi_pkg::out_t     out_next;
    logic signed [15:0] nrm_c [0:2];

    always_comb begin
        sbi_pkg::hit_rec_t r;
        logic signed [15:0] qv;
        r = rec_reg[REC_DLY];
        for (int a = 0; a < 3; a++) begin
            qv = $signed({1'b0, nq_reg[NS][a]});
            if (r.org_in) begin
                // origin inside: minus the extent, normalized; zero extent gives zero
                if (!nnz_reg[NS]) begin
                    nrm_c[a] = '0;
                end else begin
                    nrm_c[a] = epos_reg[NRM_DONE][a] ? -qv : qv;
                end
            end else if (r.nwin[a]) begin
                nrm_c[a] = r.npos ? sbi_pkg::NORM_POS : sbi_pkg::NORM_NEG;
            end else begin
                nrm_c[a] = '0;
            end
        end
        out_next.hit        = r.hit;
        out_next.inside_res = r.org_in;
        out_next.hit_param  = r.t;
        out_next.normal_x   = nrm_c[0];
        out_next.normal_y   = nrm_c[1];
        out_next.normal_z   = nrm_c[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // ---------------- checks ----------------
    `SBI_ASSERT_NOW(a_miss_clean, aclk, aresetn, m_valid && !m_data.hit, (m_data.hit_param == 17'd0) && (m_data.normal_x == 16'sd0) && (m_data.normal_y == 16'sd0) && (m_data.normal_z == 16'sd0), "miss with nonzero t or normal")
    `SBI_ASSERT_NOW(a_inside_hit, aclk, aresetn, m_valid && m_data.inside_res, m_data.hit && (m_data.hit_param == 17'd0), "inside result without hit or with nonzero t")
    `SBI_ASSERT_NOW(a_face_one, aclk, aresetn, m_valid && m_data.hit && !m_data.inside_res, $countones({m_data.normal_x != 16'sd0, m_data.normal_y != 16'sd0, m_data.normal_z != 16'sd0}) == 1, "face hit without exactly one normal axis")
    `SBI_ASSERT_NOW(a_t_range, aclk, aresetn, m_valid, m_data.hit_param <= 17'd65536, "entry parameter above one")
    `SBI_ASSERT_NEXT(a_enter, aclk, aresetn, s_valid && s_ready, vld_reg[0], "accepted request not in first stage")

endmodule

/* tb/sv/tb.sv */
// self-checking testbench for the segment versus axis-aligned box test
`timescale 1ns / 1ps

module tb;

    logic          aclk;
    logic          aresetn;
    logic          cfg_wr_en;
    logic [2:0]    cfg_index;
    logic [31:0]   cfg_wdata;
    logic          s_valid;
    logic          s_ready;
    sbi_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    sbi_pkg::out_t m_data;

    segment_box_intersect_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    localparam int LATENCY   = 52;
    localparam int MAX_CYCLE = 2000000;

    // predictor copy of the box, 64-bit signed
    longint bmin[3];
    longint bmax[3];

    sbi_pkg::in_t  pending_reqs[$];
    sbi_pkg::out_t expected_hits[$];
    int     errors;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off;
    longint cycle_count;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // cycle guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("segment_box_intersect_top regression: fail");
            $finish;
        end
    end

    function automatic longint mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // slab of one axis: 0 miss, 1 candidate, 2 inside slab
    function automatic int slab_test(longint o, longint e, longint lo, longint hi,
                                     output longint t, output int face);
        longint d;
        t = -1;
        face = 0;
        if (o < lo) begin
            d = lo - o;
            if (e < d) return 0;
            face = -1;
        end else if (o > hi) begin
            d = hi - o;
            if (d < e) return 0;
            face = 1;
        end else begin
            return 2;
        end
        t = (mag64(d) * 65536) / mag64(e);
        return 1;
    endfunction

    // hit point on an axis lies within the slab, inclusive
    function automatic bit on_slab(longint o, longint e, longint t, longint lo, longint hi);
        longint p;
        p = o * 65536 + e * t;
        return (p >= lo * 65536) && (p <= hi * 65536);
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // component of -extent/|extent| in Q1.14, rounded half away from zero
    function automatic logic signed [15:0] unit_comp(longint e, longint len);
        longint q;
        q = (mag64(e) * 32768 + len) / (2 * len);
        return (e > 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic sbi_pkg::out_t predict_intersect(sbi_pkg::in_t r);
        sbi_pkg::out_t res;
        longint o[3], e[3], t[3], tw;
        int     f[3], k[3], a;
        longint unsigned s, len;
        res = '0;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        e[0] = r.extent_x; e[1] = r.extent_y; e[2] = r.extent_z;
        for (int i = 0; i < 3; i++) begin
            t[i] = -1;
            f[i] = 0;
            k[i] = 0;
        end
        k[0] = slab_test(o[0], e[0], bmin[0], bmax[0], t[0], f[0]);
        if (k[0] != 0) k[1] = slab_test(o[1], e[1], bmin[1], bmax[1], t[1], f[1]);
        if (k[1] != 0) k[2] = slab_test(o[2], e[2], bmin[2], bmax[2], t[2], f[2]);
        if (k[0] == 0 || k[1] == 0 || k[2] == 0) return res;
        if (k[0] == 2 && k[1] == 2 && k[2] == 2) begin
            res.hit = 1'b1;
            res.inside_res = 1'b1;
            s = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
            if (s != 0) begin
                len = floor_sqrt(s);
                res.normal_x = unit_comp(e[0], len);
                res.normal_y = unit_comp(e[1], len);
                res.normal_z = unit_comp(e[2], len);
            end
            return res;
        end
        // x beats y on a tie, z only when strictly larger
        a = (t[0] >= t[1]) ? 0 : 1;
        if (t[2] > t[a]) a = 2;
        tw = t[a];
        for (int i = 0; i < 3; i++)
            if (i != a && !on_slab(o[i], e[i], tw, bmin[i], bmax[i])) return res;
        res.hit = 1'b1;
        res.hit_param = tw[16:0];
        case (a)
            0: res.normal_x = (f[0] > 0) ? sbi_pkg::NORM_POS : sbi_pkg::NORM_NEG;
            1: res.normal_y = (f[1] > 0) ? sbi_pkg::NORM_POS : sbi_pkg::NORM_NEG;
            default: res.normal_z = (f[2] > 0) ? sbi_pkg::NORM_POS : sbi_pkg::NORM_NEG;
        endcase
        return res;
    endfunction

    // driver: offers queued requests, holds payload until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // keep offering
        end else begin
            if (s_valid) begin
                expected_hits.push_back(predict_intersect(s_data));
                void'(pending_reqs.pop_front());
            end
            // the request on offer stays at the head of the queue
            if (pending_reqs.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_reqs[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // monitor: compares each result with the oldest expectation
    always @(posedge aclk) begin
        sbi_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected result count", 1, 0);
            end else begin
                want = expected_hits.pop_front();
                if (m_data.hit !== want.hit)
                    report_mismatch("hit", m_data.hit, want.hit);
                if (m_data.inside_res !== want.inside_res)
                    report_mismatch("inside_res", m_data.inside_res, want.inside_res);
                if (m_data.hit_param !== want.hit_param)
                    report_mismatch("hit_param", m_data.hit_param, want.hit_param);
                if (m_data.normal_x !== want.normal_x)
                    report_mismatch("normal_x", m_data.normal_x, want.normal_x);
                if (m_data.normal_y !== want.normal_y)
                    report_mismatch("normal_y", m_data.normal_y, want.normal_y);
                if (m_data.normal_z !== want.normal_z)
                    report_mismatch("normal_z", m_data.normal_z, want.normal_z);
            end
        end
    end

    // receiver back-pressure, with a long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one register write per clock; the caller drops the enable afterwards
    task automatic write_box(logic [2:0] idx, logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        case (idx)
            sbi_pkg::CFG_BOX_MIN_X: bmin[0] = $signed(v);
            sbi_pkg::CFG_BOX_MIN_Y: bmin[1] = $signed(v);
            sbi_pkg::CFG_BOX_MIN_Z: bmin[2] = $signed(v);
            sbi_pkg::CFG_BOX_MAX_X: bmax[0] = $signed(v);
            sbi_pkg::CFG_BOX_MAX_Y: bmax[1] = $signed(v);
            default:                bmax[2] = $signed(v);
        endcase
    endtask

    task automatic set_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                           logic [31:0] x1, logic [31:0] y1, logic [31:0] z1);
        write_box(sbi_pkg::CFG_BOX_MIN_X, x0);
        write_box(sbi_pkg::CFG_BOX_MIN_Y, y0);
        write_box(sbi_pkg::CFG_BOX_MIN_Z, z0);
        write_box(sbi_pkg::CFG_BOX_MAX_X, x1);
        write_box(sbi_pkg::CFG_BOX_MAX_Y, y1);
        write_box(sbi_pkg::CFG_BOX_MAX_Z, z1);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for the pipeline to drain before touching the box
    task automatic drain();
        while (pending_reqs.size() != 0 || s_valid || expected_hits.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word(int sel);
        case (sel)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return $signed($urandom_range(16'hffff, 0)) - 32'sd32768 <<< 4;
        endcase
    endfunction

    // segment aimed at the box: origin near, extent often reaching inside
    task automatic queue_aimed(int scale);
        sbi_pkg::in_t r;
        longint o, e, c;
        for (int i = 0; i < 3; i++) begin
            c = (bmin[i] >>> 1) + (bmax[i] >>> 1);
            o = c + $signed($urandom()) % (longint'(scale) * 3 + 1);
            if ($urandom_range(9) == 0) o = bmin[i];
            if ($urandom_range(9) == 0) o = bmax[i];
            e = (c - o) * longint'($urandom_range(3))
              + $signed($urandom()) % (longint'(scale) + 1);
            if ($urandom_range(7) == 0) e = 0;
            if (o > 64'sh7fffffff) o = 64'sh7fffffff;
            if (o < -64'sh80000000) o = -64'sh80000000;
            if (e > 64'sh7fffffff) e = 64'sh7fffffff;
            if (e < -64'sh80000000) e = -64'sh80000000;
            case (i)
                0: begin r.origin_x = o[31:0]; r.extent_x = e[31:0]; end
                1: begin r.origin_y = o[31:0]; r.extent_y = e[31:0]; end
                default: begin r.origin_z = o[31:0]; r.extent_z = e[31:0]; end
            endcase
        end
        pending_reqs.push_back(r);
    endtask

    task automatic queue_noise();
        sbi_pkg::in_t r;
        r.origin_x = rand_word($urandom_range(3));
        r.origin_y = rand_word($urandom_range(3));
        r.origin_z = rand_word($urandom_range(3));
        r.extent_x = rand_word($urandom_range(3));
        r.extent_y = rand_word($urandom_range(3));
        r.extent_z = rand_word($urandom_range(3));
        pending_reqs.push_back(r);
    endtask

    task automatic queue_req(longint ox, longint oy, longint oz,
                             longint ex, longint ey, longint ez);
        sbi_pkg::in_t r;
        r.origin_x = ox[31:0]; r.origin_y = oy[31:0]; r.origin_z = oz[31:0];
        r.extent_x = ex[31:0]; r.extent_y = ey[31:0]; r.extent_z = ez[31:0];
        pending_reqs.push_back(r);
    endtask

    task automatic random_phase(int count, int scale);
        for (int i = 0; i < count; i++)
            if ($urandom_range(99) < 80) queue_aimed(scale);
            else queue_noise();
        drain();
    endtask

    initial begin
        errors = 0;
        cycle_count = 0;
        hold_off = 0;
        send_idle_pct = 15;
        recv_idle_pct = 72;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        for (int i = 0; i < 3; i++) begin
            bmin[i] = 0;
            bmax[i] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero box from reset: degenerate point box
        queue_req(0, 0, 0, 0, 0, 0);
        queue_req(-65536, 0, 0, 131072, 0, 0);
        drain();

        // unit box, directed cases
        set_box(32'hffff0000, 32'hffff0000, 32'hffff0000,
                32'h00010000, 32'h00010000, 32'h00010000);
        queue_req(0, 0, 0, 0, 0, 0);                      // inside, zero extent
        queue_req(0, 0, 0, 65536, -65536, 32768);         // inside, normalized
        queue_req(0, 0, 0, -32'sh80000000, 32'sh7fffffff, -32'sh80000000);
        queue_req(-131072, 0, 0, 131072, 0, 0);           // min face x, t=1/2
        queue_req(131072, 0, 0, -65536, 0, 0);            // max face x, t=1
        queue_req(0, -131072, 0, 0, 262144, 0);           // y face
        queue_req(0, 0, 131072, 0, 0, -262144);           // z face
        queue_req(-131072, -131072, 0, 131072, 131072, 0);// x/y tie, x wins
        queue_req(-131072, -131072, -131072, 131072, 131072, 131072);
        queue_req(-131072, 0, 0, 65535, 0, 0);            // falls short
        queue_req(-131072, 0, 0, 131072, 0, 0);
        queue_req(-131072, 131072, 0, 131072, 0, 0);      // misses on y
        queue_req(-131072, 65536, 0, 65536, 0, 0);        // grazes edge
        queue_req(-32'sh80000000, -32'sh80000000, -32'sh80000000,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        queue_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                  -32'sh80000000, -32'sh80000000, -32'sh80000000);
        queue_req(32'sh7fffffff, 0, 0, -32'sh80000000, 0, 0);
        drain();

        // extreme box and inverted box
        set_box(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        queue_req(0, 0, 0, 1, 2, 3);
        queue_req(-32'sh80000000, 32'sh7fffffff, 0, -1, 1, 0);
        drain();
        set_box(32'h00010000, 32'h00010000, 32'h00010000,
                32'hffff0000, 32'hffff0000, 32'hffff0000);
        queue_req(0, 0, 0, 65536, 65536, 65536);
        queue_req(-131072, 0, 0, 262144, 0, 0);
        drain();

        // random: sender idles lightly, receiver heavily
        set_box(32'hfffc0000, 32'hffff8000, 32'hfffe0000,
                32'h00030000, 32'h00028000, 32'h00010000);
        random_phase(400, 32'h40000);

        // swap idling; long receiver hold-off lets the pipeline fill
        send_idle_pct = 72;
        recv_idle_pct = 15;
        set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        random_phase(150, 32'h7fffffff);
        set_box(32'h80000000, 32'hfff00000, 32'h00000000,
                32'h7fffffff, 32'h00100000, 32'h00000000);
        send_idle_pct = 0;
        hold_off = 300;
        random_phase(350, 32'h200000);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_box(32'hffff0000, 32'hfffe0000, 32'hfffd0000,
                32'h00010000, 32'h00020000, 32'h00030000);
        random_phase(600, 32'h50000);

        if (errors == 0) begin
            $display("segment_box_intersect_top regression: pass");
        end else begin
            $display("segment_box_intersect_top regression: fail");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/sbi_pkg.sv
rtl/segment_box_intersect_top.sv
tb/sv/tb.sv
